// ===== hw/rtl/wphc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// wphc_pkg
// Types and constants for the waypoint heading controller.
// ---------------------------------------------------------------------------
package wphc_pkg;

    // event codes
    localparam logic [2:0] OP_POSITION = 3'd0;
    localparam logic [2:0] OP_SETPOINT = 3'd1;
    localparam logic [2:0] OP_TICK     = 3'd2;
    localparam logic [2:0] OP_START    = 3'd3;
    localparam logic [2:0] OP_STOP     = 3'd4;

    // register indexes
    localparam logic REG_MAX_SPEED = 1'b0;
    localparam logic REG_TOLERANCE = 1'b1;

    localparam logic [15:0] MAX_SPEED_RST = 16'd1024;
    localparam logic [22:0] TOLERANCE_RST = 23'd256;

    localparam logic CMD_STOP    = 1'b0;
    localparam logic CMD_HEADING = 1'b1;

    // angle accumulator, 2^-20 rad
    localparam int ZW = 24;
    localparam logic signed [ZW-1:0] Z_HALF_PI = 24'sd1647100;

    // direction: floor((a*1125 - hdg*160768 + 144000) / 288000), offset by
    // 65536 divisors so the dividend stays positive
    localparam logic signed [37:0] DIR_ANG_MUL = 38'sd1125;
    localparam logic signed [37:0] DIR_HDG_MUL = 38'sd160768;
    localparam logic signed [37:0] DIR_BIAS    = 38'sd18874512000;
    localparam logic [18:0]        DIR_DIVISOR = 19'd288000;
    localparam logic [16:0]        DIR_OFFSET  = 17'h10000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_CHECK,
        S_CORDIC,
        S_DIRMUL,
        S_DIRDIV,
        S_SQ1,
        S_SQ2,
        S_SQRT,
        S_DURDIV,
        S_OUT
    } t_state;

    function automatic logic [20:0] atan_lut(input logic [4:0] idx);
        logic [20:0] v;
        case (idx)
            5'd0:    v = 21'd823550;
            5'd1:    v = 21'd486171;
            5'd2:    v = 21'd256879;
            5'd3:    v = 21'd130396;
            5'd4:    v = 21'd65451;
            5'd5:    v = 21'd32757;
            5'd6:    v = 21'd16383;
            5'd7:    v = 21'd8192;
            5'd8:    v = 21'd4096;
            5'd9:    v = 21'd2048;
            5'd10:   v = 21'd1024;
            5'd11:   v = 21'd512;
            5'd12:   v = 21'd256;
            5'd13:   v = 21'd128;
            5'd14:   v = 21'd64;
            5'd15:   v = 21'd32;
            5'd16:   v = 21'd16;
            5'd17:   v = 21'd8;
            5'd18:   v = 21'd4;
            5'd19:   v = 21'd2;
            5'd20:   v = 21'd1;
            default: v = 21'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/waypoint_heading_controller_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// waypoint_heading_controller_top
// Event driven rover controller: stores pose and goal, and on each tick
// while running emits a stop or a heading command toward the goal.
// ---------------------------------------------------------------------------
// Usage
//   Input channel (i_in_valid / o_in_stall) carries one event per beat:
//   position update, setpoint update, tick, start or stop. Output channel
//   (o_out_valid / i_out_stall) carries at most one command beat per event.
//   Config port (i_cfg_we / i_cfg_idx / i_cfg_data) writes max_speed and
//   arrival_tolerance; write it only while the block is idle.
// Sequence
//   Updates, start and ignored events are handled while idle and give no
//   command. A stop goes straight to the output stage, a tick inside the
//   arrival box through difference and box check to it; the input stalls
//   until the command is loaded into the output register. A heading tick
//   runs a sequencer over shared serial units: difference and box check,
//   CORDIC vectoring (skipped for a zero vector), numerator, restoring
//   divider for the direction, squares, bit-pair square root, divider
//   again for the duration and output load.
// Reset
//   Synchronous, active low: pose and goal zero, stopped, registers at
//   their reset values, output empty.
// Stall
//   A finished command waits in the output register; the block keeps taking
//   events while it waits, and only holds its next command until it drains.
// ---------------------------------------------------------------------------
module waypoint_heading_controller_top #(
    parameter int POS_WIDTH    = 24,
    parameter int CORDIC_STEPS = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    // event input
    input  wire                         i_in_valid,
    output logic                        o_in_stall,
    input  wire  [2:0]                  i_op,
    input  wire  signed [POS_WIDTH-1:0] i_x_pos,
    input  wire  signed [POS_WIDTH-1:0] i_y_pos,
    input  wire  signed [16:0]          i_heading_deg,
    // command output
    output logic                        o_out_valid,
    input  wire                         i_out_stall,
    output logic                        o_command_kind,
    output logic signed [16:0]          o_direction_rad,
    output logic [15:0]                 o_speed,
    output logic [31:0]                 o_duration_ms,
    // config write
    input  wire                         i_cfg_we,
    input  wire                         i_cfg_idx,
    input  wire  [22:0]                 i_cfg_data
);

    localparam int DW    = POS_WIDTH + 1;        // axis difference
    localparam int CW    = POS_WIDTH + 29;       // CORDIC x/y, scaled by 2^26
    localparam int SW    = 2 * POS_WIDTH + 2;    // sum of squares
    localparam int RTW   = POS_WIDTH + 1;        // square root
    localparam int RMW   = POS_WIDTH + 4;        // root remainder
    localparam int NUM_W = (POS_WIDTH + 11 > 36) ? POS_WIDTH + 11 : 36;
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam int ZW    = wphc_pkg::ZW;
    localparam int TW    = (POS_WIDTH + 1 > 23) ? POS_WIDTH + 1 : 23;  // box compare

    // configuration and stored state
    logic [15:0]                 r_max_speed;
    logic [22:0]                 r_tol;
    logic signed [POS_WIDTH-1:0] r_rover_x, r_rover_y, r_goal_x, r_goal_y;
    logic signed [16:0]          r_heading;
    logic                        r_running;

    wphc_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt;

    logic signed [DW-1:0]    r_dx, r_dy;
    logic [POS_WIDTH-1:0]    r_ax, r_ay;
    logic signed [CW-1:0]    r_cx, r_cy;
    logic signed [ZW-1:0]    r_cz;
    logic [NUM_W-1:0]        r_num;
    logic [18:0]             r_rem;
    logic [18:0]             r_dvs;
    logic signed [16:0]      r_dir;
    logic [SW-1:0]           r_rad;
    logic [RTW-1:0]          r_root;
    logic [RMW-1:0]          r_srem;
    logic                    r_kind;

    logic                    r_out_valid;
    logic                    r_out_kind;
    logic signed [16:0]      r_out_dir;
    logic [15:0]             r_out_speed;
    logic [31:0]             r_out_dur;

    logic in_acc, out_free, out_load, cnt_last, in_box, zero_vec;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign in_box   = (TW'(r_ax) < TW'(r_tol)) && (TW'(r_ay) < TW'(r_tol));
    assign zero_vec = (r_dx == '0) && (r_dy == '0);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            wphc_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (i_op == wphc_pkg::OP_STOP) begin
                        n_state = wphc_pkg::S_OUT;
                    end else if (i_op == wphc_pkg::OP_TICK && r_running) begin
                        n_state = wphc_pkg::S_DIFF;
                    end
                end
            end
            wphc_pkg::S_DIFF:  n_state = wphc_pkg::S_CHECK;
            wphc_pkg::S_CHECK: begin
                if (in_box) begin
                    n_state = wphc_pkg::S_OUT;
                end else if (zero_vec) begin
                    n_state = wphc_pkg::S_DIRMUL;
                end else begin
                    n_state = wphc_pkg::S_CORDIC;
                end
            end
            wphc_pkg::S_CORDIC: if (cnt_last) n_state = wphc_pkg::S_DIRMUL;
            wphc_pkg::S_DIRMUL: n_state = wphc_pkg::S_DIRDIV;
            wphc_pkg::S_DIRDIV: if (cnt_last) n_state = wphc_pkg::S_SQ1;
            wphc_pkg::S_SQ1:    n_state = wphc_pkg::S_SQ2;
            wphc_pkg::S_SQ2:    n_state = wphc_pkg::S_SQRT;
            wphc_pkg::S_SQRT:   if (cnt_last) n_state = wphc_pkg::S_DURDIV;
            wphc_pkg::S_DURDIV: if (cnt_last) n_state = wphc_pkg::S_OUT;
            wphc_pkg::S_OUT:    if (out_free) n_state = wphc_pkg::S_IDLE;
            default:            n_state = wphc_pkg::S_IDLE;
        endcase
    end

    // state decoded controls
    always_comb begin
        o_in_stall = (r_state != wphc_pkg::S_IDLE);
        out_load   = (r_state == wphc_pkg::S_OUT) && out_free;
        case (r_state)
            wphc_pkg::S_CORDIC: cnt_last = (r_cnt == CNT_W'(CORDIC_STEPS - 1));
            wphc_pkg::S_DIRDIV: cnt_last = (r_cnt == CNT_W'(NUM_W - 1));
            wphc_pkg::S_SQRT:   cnt_last = (r_cnt == CNT_W'(RTW - 1));
            wphc_pkg::S_DURDIV: cnt_last = (r_cnt == CNT_W'(NUM_W - 1));
            default:            cnt_last = 1'b0;
        endcase
    end

    // datapath helpers
    logic signed [CW-1:0]       xl, yl, xs, ys;
    logic signed [ZW-1:0]       atan_z;
    logic signed [37:0]         dir_num;
    logic [19:0]                div_t;
    logic                       div_bit;
    logic [RMW-1:0]             sq_t, sq_trial;
    logic                       sq_bit;
    logic [POS_WIDTH-1:0]       sq_src;
    logic [2*POS_WIDTH-1:0]     sq_prod;

    assign xl       = CW'(r_dx) <<< 26;
    assign yl       = CW'(r_dy) <<< 26;
    assign xs       = r_cx >>> r_cnt[4:0];
    assign ys       = r_cy >>> r_cnt[4:0];
    assign atan_z   = $signed({3'b000, wphc_pkg::atan_lut(r_cnt[4:0])});
    assign dir_num  = 38'(r_cz) * wphc_pkg::DIR_ANG_MUL
                    - 38'(r_heading) * wphc_pkg::DIR_HDG_MUL + wphc_pkg::DIR_BIAS;
    assign div_t    = {r_rem, r_num[NUM_W-1]};
    assign div_bit  = (div_t >= {1'b0, r_dvs});
    assign sq_t     = {r_srem[RMW-3:0], r_rad[SW-1:SW-2]};
    assign sq_trial = RMW'({r_root, 2'b01});
    assign sq_bit   = (sq_t >= sq_trial);
    // one squarer, x axis then y axis
    assign sq_src   = (r_state == wphc_pkg::S_SQ1) ? r_ax : r_ay;
    assign sq_prod  = {{POS_WIDTH{1'b0}}, sq_src} * {{POS_WIDTH{1'b0}}, sq_src};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wphc_pkg::S_IDLE;
            r_cnt       <= '0;
            r_running   <= 1'b0;
            r_max_speed <= wphc_pkg::MAX_SPEED_RST;
            r_tol       <= wphc_pkg::TOLERANCE_RST;
            r_rover_x   <= '0;
            r_rover_y   <= '0;
            r_heading   <= '0;
            r_goal_x    <= '0;
            r_goal_y    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= (cnt_last || n_state != r_state) ? '0 : r_cnt + 1'b1;

            if (i_cfg_we) begin
                if (i_cfg_idx == wphc_pkg::REG_MAX_SPEED) begin
                    r_max_speed <= i_cfg_data[15:0];
                end else begin
                    r_tol <= i_cfg_data;
                end
            end

            if (in_acc) begin
                case (i_op)
                    wphc_pkg::OP_POSITION: begin
                        r_rover_x <= i_x_pos;
                        r_rover_y <= i_y_pos;
                        r_heading <= i_heading_deg;
                    end
                    wphc_pkg::OP_SETPOINT: begin
                        r_goal_x <= i_x_pos;
                        r_goal_y <= i_y_pos;
                    end
                    wphc_pkg::OP_START: r_running <= 1'b1;
                    wphc_pkg::OP_STOP:  r_running <= 1'b0;
                    default: ;
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        case (r_state)
            wphc_pkg::S_IDLE: r_kind <= wphc_pkg::CMD_STOP;
            wphc_pkg::S_DIFF: begin
                r_dx <= DW'(r_goal_x) - DW'(r_rover_x);
                r_dy <= DW'(r_goal_y) - DW'(r_rover_y);
                r_ax <= (r_goal_x >= r_rover_x) ? POS_WIDTH'(r_goal_x - r_rover_x)
                                                : POS_WIDTH'(r_rover_x - r_goal_x);
                r_ay <= (r_goal_y >= r_rover_y) ? POS_WIDTH'(r_goal_y - r_rover_y)
                                                : POS_WIDTH'(r_rover_y - r_goal_y);
            end
            wphc_pkg::S_CHECK: begin
                r_kind <= in_box ? wphc_pkg::CMD_STOP : wphc_pkg::CMD_HEADING;
                // quadrant pre-rotation for a left half-plane vector
                if (!r_dx[DW-1]) begin
                    r_cx <= xl;
                    r_cy <= yl;
                    r_cz <= '0;
                end else if (!r_dy[DW-1]) begin
                    r_cx <= yl;
                    r_cy <= -xl;
                    r_cz <= wphc_pkg::Z_HALF_PI;
                end else begin
                    r_cx <= -yl;
                    r_cy <= xl;
                    r_cz <= -wphc_pkg::Z_HALF_PI;
                end
                if (zero_vec) r_cz <= '0;
            end
            wphc_pkg::S_CORDIC: begin
                if (!r_cy[CW-1]) begin
                    r_cx <= r_cx + ys;
                    r_cy <= r_cy - xs;
                    r_cz <= r_cz + atan_z;
                end else begin
                    r_cx <= r_cx - ys;
                    r_cy <= r_cy + xs;
                    r_cz <= r_cz - atan_z;
                end
            end
            wphc_pkg::S_DIRMUL: begin
                r_num <= NUM_W'(dir_num[35:0]);
                r_rem <= '0;
                r_dvs <= wphc_pkg::DIR_DIVISOR;
            end
            wphc_pkg::S_DIRDIV, wphc_pkg::S_DURDIV: begin
                r_num <= {r_num[NUM_W-2:0], div_bit};
                r_rem <= div_bit ? 19'(div_t - {1'b0, r_dvs}) : div_t[18:0];
            end
            wphc_pkg::S_SQ1: begin
                r_dir <= $signed(r_num[16:0] - wphc_pkg::DIR_OFFSET);
                r_rad <= SW'(sq_prod);
            end
            wphc_pkg::S_SQ2: begin
                r_rad  <= r_rad + SW'(sq_prod);
                r_root <= '0;
                r_srem <= '0;
            end
            wphc_pkg::S_SQRT: begin
                r_rad  <= {r_rad[SW-3:0], 2'b00};
                r_srem <= sq_bit ? sq_t - sq_trial : sq_t;
                r_root <= {r_root[RTW-2:0], sq_bit};
                if (cnt_last) begin
                    r_num <= NUM_W'({r_root[RTW-2:0], sq_bit}) * NUM_W'(1000);
                    r_rem <= '0;
                    r_dvs <= 19'(r_max_speed);
                end
            end
            default: ;
        endcase

        if (out_load) begin
            r_out_kind <= r_kind;
            if (r_kind == wphc_pkg::CMD_HEADING) begin
                r_out_dir   <= r_dir;
                r_out_speed <= r_max_speed;
                r_out_dur   <= (|r_num[NUM_W-1:32]) ? 32'hFFFF_FFFF : r_num[31:0];
            end else begin
                r_out_dir   <= '0;
                r_out_speed <= '0;
                r_out_dur   <= '0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_command_kind  = r_out_kind;
    assign o_direction_rad = r_out_dir;
    assign o_speed         = r_out_speed;
    assign o_duration_ms   = r_out_dur;

    // checks
    a_stop_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_command_kind == wphc_pkg::CMD_STOP) |->
            (o_direction_rad == '0) && (o_speed == '0) && (o_duration_ms == '0))
        else $error("stop command with non-zero fields");

    a_stop_to_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_op == wphc_pkg::OP_STOP) |=> (r_state == wphc_pkg::S_OUT))
        else $error("stop event did not reach output stage");

    a_run_fall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_running) && $past(i_rst_n) |-> $past(in_acc && (i_op == wphc_pkg::OP_STOP)))
        else $error("running cleared without stop event");

    a_cordic_cnt : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wphc_pkg::S_CORDIC) |-> (r_cnt < CNT_W'(CORDIC_STEPS)))
        else $error("CORDIC step count overrun");

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for waypoint_heading_controller_top. A directed table
// of events is walked first, then random event streams under several
// register settings. Every accepted event goes through a local model of the
// controller. Every command beat is compared field by field with the oldest
// outstanding expectation.
// ---------------------------------------------------------------------------
module tb_top;

    // reserved event codes, the block must ignore them
    localparam logic [2:0] OP_RSVD_FIRST = 3'd5;
    localparam logic [2:0] OP_RSVD_MID   = 3'd6;
    localparam logic [2:0] OP_RSVD_LAST  = 3'd7;

    localparam int POS_W        = 24;
    localparam int CORDIC_ITERS = 16;
    localparam int DRAIN_CYCLES = 200;
    localparam int STALL_LIMIT  = 4000;  // cycles with no beat on either side
    localparam int RAND_ITEMS   = 150;   // per register setting, five settings

    typedef struct packed {
        logic        kind;
        logic [16:0] dir;
        logic [15:0] speed;
        logic [31:0] dur;
    } t_cmd;

    // how a directed row is checked
    typedef enum logic [1:0] {
        EXP_NONE,  // no command
        EXP_STOP,  // stop command, all fields zero
        EXP_PRED   // worked out by the local model
    } t_exp_mode;

    typedef struct packed {
        logic [2:0]              op;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [16:0]      hdg;
        t_exp_mode               mode;
    } t_event_row;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic [2:0]              i_op;
    logic signed [POS_W-1:0] i_x_pos;
    logic signed [POS_W-1:0] i_y_pos;
    logic signed [16:0]      i_heading_deg;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic                    o_command_kind;
    logic signed [16:0]      o_direction_rad;
    logic [15:0]             o_speed;
    logic [31:0]             o_duration_ms;
    logic                    i_cfg_we;
    logic                    i_cfg_idx;
    logic [22:0]             i_cfg_data;

    waypoint_heading_controller_top #(
        .POS_WIDTH   (POS_W),
        .CORDIC_STEPS(CORDIC_ITERS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_x_pos        (i_x_pos),
        .i_y_pos        (i_y_pos),
        .i_heading_deg  (i_heading_deg),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_command_kind (o_command_kind),
        .o_direction_rad(o_direction_rad),
        .o_speed        (o_speed),
        .o_duration_ms  (o_duration_ms),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    // model state: pose, goal, run flag, registers
    longint      rover_x, rover_y, rover_hdg, goal_x, goal_y;
    bit          running;
    longint      speed_reg, tol_reg;

    t_cmd        cmd_expected[$];
    int          mismatches = 0;
    int          quiet_cycles;
    bit          idling_on;

    // atan(2^-i) in 2^-20 rad
    localparam longint ATAN_STEP [16] = '{
        823550, 486171, 256879, 130396, 65451, 32757, 16383, 8192,
        4096, 2048, 1024, 512, 256, 128, 64, 32
    };

    // -----------------------------------------------------------------------
    // Clock
    // -----------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // -----------------------------------------------------------------------
    // Local model of the controller
    // -----------------------------------------------------------------------
    // atan2 by vectoring, result in 2^-20 rad; >>> on longint is a floor shift
    function automatic longint vector_angle(input longint dy, input longint dx);
        longint x, y, z, t, xs, ys;
        x = dx <<< 26;
        y = dy <<< 26;
        z = 0;
        if (dx == 0 && dy == 0)
            return 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y;  y = -t; z = 1647100;
            end else begin
                t = x; x = -y; y = t;  z = -1647100;
            end
        end
        for (int i = 0; i < CORDIC_ITERS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys; y -= xs; z += ATAN_STEP[i];
            end else begin
                x -= ys; y += xs; z -= ATAN_STEP[i];
            end
        end
        return z;
    endfunction

    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned root, trial;
        root = 0;
        for (int i = 31; i >= 0; i--) begin
            trial = root | (64'd1 << i);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    // updates the model for one event; returns 1 when a command results
    function automatic bit heading_cmd_predict(input logic [2:0] op,
                                               input logic signed [POS_W-1:0] x,
                                               input logic signed [POS_W-1:0] y,
                                               input logic signed [16:0] hdg,
                                               output t_cmd cmd);
        longint dx, dy, ax, ay, ang, num, dir;
        longint unsigned root_len, dur;
        cmd = '0;
        case (op)
            wphc_pkg::OP_POSITION: begin
                rover_x = x; rover_y = y; rover_hdg = hdg;
                return 0;
            end
            wphc_pkg::OP_SETPOINT: begin
                goal_x = x; goal_y = y;
                return 0;
            end
            wphc_pkg::OP_START: begin
                running = 1'b1;
                return 0;
            end
            wphc_pkg::OP_STOP: begin
                running = 1'b0;
                cmd.kind = wphc_pkg::CMD_STOP;
                return 1;
            end
            wphc_pkg::OP_TICK: ;
            default: return 0;
        endcase
        if (!running)
            return 0;
        dx = goal_x - rover_x;
        dy = goal_y - rover_y;
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        if (ax < tol_reg && ay < tol_reg) begin
            cmd.kind = wphc_pkg::CMD_STOP;
            return 1;
        end
        ang = vector_angle(dy, dx);
        num = ang * 1125 - rover_hdg * 628 * 256 + 144000;
        dir = num / 288000;
        if (num % 288000 != 0 && num < 0)
            dir--;
        root_len = floor_root(ax * ax + ay * ay);
        if (speed_reg == 0)
            dur = 64'hFFFF_FFFF;
        else begin
            dur = (1000 * root_len) / speed_reg;
            if (dur > 64'hFFFF_FFFF)
                dur = 64'hFFFF_FFFF;
        end
        cmd.kind  = wphc_pkg::CMD_HEADING;
        cmd.dir   = dir[16:0];
        cmd.speed = speed_reg[15:0];
        cmd.dur   = dur[31:0];
        return 1;
    endfunction

    // -----------------------------------------------------------------------
    // Sender: one event beat, held until the block takes it
    // -----------------------------------------------------------------------
    task automatic send_event(input logic [2:0] op,
                              input logic signed [POS_W-1:0] x,
                              input logic signed [POS_W-1:0] y,
                              input logic signed [16:0] hdg,
                              input t_exp_mode mode);
        t_cmd cmd;
        bit   has_cmd;
        // random gap ahead of the beat, valid low meanwhile
        if (idling_on && $urandom_range(99) < 27) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < 27)
                @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_op          <= op;
        i_x_pos       <= x;
        i_y_pos       <= y;
        i_heading_deg <= hdg;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        // beat taken at this edge
        has_cmd = heading_cmd_predict(op, x, y, hdg, cmd);
        if (mode == EXP_STOP)
            cmd_expected.push_back('0);
        else if (mode == EXP_PRED && has_cmd)
            cmd_expected.push_back(cmd);
    endtask

    // let the block go idle: all commands out, then the tail of any tick
    // that yields nothing
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (cmd_expected.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [22:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == wphc_pkg::REG_MAX_SPEED)
            speed_reg = data[15:0];
        else
            tol_reg = data;
    endtask

    function automatic logic signed [16:0] rand_heading();
        return 17'($signed($urandom_range(92160)) - 46080);
    endfunction

    // coordinate: anywhere, near the goal, or on the goal
    function automatic logic signed [POS_W-1:0] rand_coord(input longint goal);
        int unsigned pick;
        pick = $urandom_range(5);
        if (pick < 2)
            return POS_W'($urandom);
        if (pick < 5)
            return POS_W'(goal + $signed($urandom_range(2047)) - 1024);
        return POS_W'(goal);
    endfunction

    task automatic random_events(input int n_items);
        int          counted;
        int unsigned r;
        logic [2:0]  op;
        counted = 0;
        while (counted < n_items) begin
            r = $urandom_range(99);
            if (r < 25)      op = wphc_pkg::OP_POSITION;
            else if (r < 38) op = wphc_pkg::OP_SETPOINT;
            else if (r < 75) op = wphc_pkg::OP_TICK;
            else if (r < 85) op = wphc_pkg::OP_START;
            else if (r < 93) op = wphc_pkg::OP_STOP;
            else             op = 3'($urandom_range(OP_RSVD_LAST, OP_RSVD_FIRST));
            if (op == wphc_pkg::OP_POSITION)
                send_event(op, rand_coord(goal_x), rand_coord(goal_y), rand_heading(),
                           EXP_PRED);
            else if (op == wphc_pkg::OP_SETPOINT)
                send_event(op, rand_coord(rover_x), rand_coord(rover_y), rand_heading(),
                           EXP_PRED);
            else
                send_event(op, POS_W'($urandom), POS_W'($urandom), 17'($urandom),
                           EXP_PRED);
            if (op < OP_RSVD_FIRST)
                counted++;
        end
    endtask

    // -----------------------------------------------------------------------
    // Receiver stall
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_out_stall <= idling_on && ($urandom_range(99) < 27);
    end

    // -----------------------------------------------------------------------
    // Checker: each command beat against the oldest expectation
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_cmd want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (cmd_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected command beat: kind %0d dir %0d spd %0d dur %0d",
                             o_command_kind, o_direction_rad, o_speed, o_duration_ms);
            end else begin
                want = cmd_expected.pop_front();
                if (o_command_kind !== want.kind || o_direction_rad !== want.dir ||
                    o_speed !== want.speed || o_duration_ms !== want.dur) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"command mismatch: exp kind %0d dir %0d spd %0d dur %0d,",
                                  " got kind %0d dir %0d spd %0d dur %0d"},
                                 want.kind, $signed(want.dir), want.speed, want.dur,
                                 o_command_kind, o_direction_rad, o_speed, o_duration_ms);
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Watchdog: no beat on either side for too long ends the run
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT) begin
            $display("waypoint_heading_controller_top regression: fail");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    // -----------------------------------------------------------------------
    // Directed events, reset register values (speed 1024, box 256)
    // -----------------------------------------------------------------------
    localparam logic signed [POS_W-1:0] XMAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] XMIN = {1'b1, {(POS_W-1){1'b0}}};

    t_event_row directed [20] = '{
        '{wphc_pkg::OP_TICK,     0,    0,       0, EXP_NONE},  // tick while stopped
        '{wphc_pkg::OP_STOP,     0,    0,       0, EXP_STOP},  // stop while stopped
        '{wphc_pkg::OP_START,    0,    0,       0, EXP_NONE},
        '{wphc_pkg::OP_TICK,     0,    0,       0, EXP_STOP},  // on the goal
        '{wphc_pkg::OP_POSITION, XMAX, XMIN,  46080, EXP_NONE},
        '{wphc_pkg::OP_SETPOINT, XMIN, XMAX, -46080, EXP_NONE}, // heading ignored
        '{wphc_pkg::OP_TICK,     0,    0,       0, EXP_PRED},  // longest vector
        '{wphc_pkg::OP_POSITION, XMIN, XMIN, -46080, EXP_NONE},
        '{wphc_pkg::OP_SETPOINT, XMAX, XMAX,      0, EXP_NONE},
        '{wphc_pkg::OP_TICK,     0,    0,       0, EXP_PRED},
        '{OP_RSVD_FIRST,         0,    0,       0, EXP_NONE},
        '{OP_RSVD_MID,           0,    0,       0, EXP_NONE},
        '{OP_RSVD_LAST,          0,    0,       0, EXP_NONE},
        '{wphc_pkg::OP_POSITION, 100, -100,     0, EXP_NONE},
        '{wphc_pkg::OP_SETPOINT, 0,    0,       0, EXP_NONE},
        '{wphc_pkg::OP_TICK,     0,    0,       0, EXP_STOP},  // inside the box
        '{wphc_pkg::OP_POSITION, 300,  5,    1000, EXP_NONE},  // goal behind, below
        '{wphc_pkg::OP_TICK,     0,    0,       0, EXP_PRED},
        '{wphc_pkg::OP_POSITION, 256,  0,       0, EXP_NONE},  // box edge is outside
        '{wphc_pkg::OP_TICK,     0,    0,       0, EXP_PRED}
    };

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_op          = wphc_pkg::OP_POSITION;
        i_x_pos       = '0;
        i_y_pos       = '0;
        i_heading_deg = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = wphc_pkg::REG_MAX_SPEED;
        i_cfg_data    = '0;
        idling_on     = 1'b1;
        rover_x = 0; rover_y = 0; rover_hdg = 0; goal_x = 0; goal_y = 0;
        running   = 1'b0;
        speed_reg = wphc_pkg::MAX_SPEED_RST;
        tol_reg   = wphc_pkg::TOLERANCE_RST;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k])
            send_event(directed[k].op, directed[k].x, directed[k].y, directed[k].hdg,
                       directed[k].mode);
        send_event(wphc_pkg::OP_STOP, 0, 0, 0, EXP_STOP);

        // reset settings, with the sender once waiting for every command
        random_events(RAND_ITEMS / 2);
        i_in_valid <= 1'b0;
        while (cmd_expected.size() != 0)
            @(posedge i_clk);
        random_events(RAND_ITEMS / 2);

        // slowest speed, no arrival box: zero vector gives angle 0
        wait_drained();
        write_reg(wphc_pkg::REG_MAX_SPEED, 23'd1);
        write_reg(wphc_pkg::REG_TOLERANCE, 23'd0);
        random_events(RAND_ITEMS);

        // top extremes, and a stretch with no idling on either side
        wait_drained();
        write_reg(wphc_pkg::REG_MAX_SPEED, 23'd65535);
        write_reg(wphc_pkg::REG_TOLERANCE, 23'h7FFFFF);
        idling_on = 1'b0;
        random_events(RAND_ITEMS);
        idling_on = 1'b1;

        // speed zero saturates the duration
        wait_drained();
        write_reg(wphc_pkg::REG_MAX_SPEED, 23'd0);
        write_reg(wphc_pkg::REG_TOLERANCE, 23'd1000);
        random_events(RAND_ITEMS);

        wait_drained();
        write_reg(wphc_pkg::REG_MAX_SPEED, 23'($urandom_range(65535, 1)));
        write_reg(wphc_pkg::REG_TOLERANCE, 23'($urandom_range(4096)));
        random_events(RAND_ITEMS);

        wait_drained();
        if (mismatches == 0)
            $display("waypoint_heading_controller_top regression: pass");
        else
            $display("waypoint_heading_controller_top regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/wphc_pkg.sv
hw/rtl/waypoint_heading_controller_top.sv
dv/tb_top.sv
